// ===== rtl/gscw_pkg.sv =====
// Shared types and constants of the grid segment cell walk unit.
// Holds the microcode ROM for the sequencer. No dependencies.
`default_nettype none

package gscw_pkg;

  localparam int unsigned COORD_INT_BITS_DEF = 12;
  localparam int unsigned FRAC_BITS_DEF      = 8;
  localparam int unsigned MAX_CELLS_DEF      = 64;
  localparam int unsigned IN_W_DEF   = COORD_INT_BITS_DEF + FRAC_BITS_DEF + 1;
  localparam int unsigned CELL_W_DEF = COORD_INT_BITS_DEF + 1;

  // microcode step addresses
  typedef enum logic [1:0] {
    UA_IDLE,
    UA_SETUP,
    UA_MUL,
    UA_WALK
  } gscw_addr_e;

  // datapath operation of a step
  typedef enum logic [1:0] {
    DP_NOP,
    DP_SETUP,
    DP_MUL,
    DP_WALK
  } gscw_dpop_e;

  // branch condition: jump to target when true, else hold the step
  typedef enum logic [1:0] {
    BR_ALWAYS,
    BR_ACCEPT,
    BR_MUL_DONE,
    BR_WALK_END
  } gscw_br_e;

  typedef struct packed {
    logic       in_ready;
    gscw_dpop_e op;
    gscw_br_e   br;
    gscw_addr_e target;
  } gscw_ctrl_t;

  typedef struct packed {
    logic accept;
    logic mul_done;
    logic walk_fire;
    logic walk_last;
  } gscw_stat_t;

  function automatic gscw_ctrl_t gscw_ucode(input gscw_addr_e addr);
    gscw_ctrl_t cw;
    unique case (addr)
      UA_IDLE:  cw = '{in_ready: 1'b1, op: DP_NOP,   br: BR_ACCEPT,   target: UA_SETUP};
      UA_SETUP: cw = '{in_ready: 1'b0, op: DP_SETUP, br: BR_ALWAYS,   target: UA_MUL};
      UA_MUL:   cw = '{in_ready: 1'b0, op: DP_MUL,   br: BR_MUL_DONE, target: UA_WALK};
      UA_WALK:  cw = '{in_ready: 1'b0, op: DP_WALK,  br: BR_WALK_END, target: UA_IDLE};
      default:  cw = '{in_ready: 1'b0, op: DP_NOP,   br: BR_ALWAYS,   target: UA_IDLE};
    endcase
    return cw;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/gscw_if.sv =====
// Valid/ready channel interfaces: segment words in, cell words out.
// Depends on gscw_pkg for default widths.
`default_nettype none

interface gscw_seg_if #(
  parameter int unsigned IN_W = gscw_pkg::IN_W_DEF
);
  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] start_x;
  logic signed [IN_W-1:0] start_y;
  logic signed [IN_W-1:0] end_x;
  logic signed [IN_W-1:0] end_y;

  modport source (output valid, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface gscw_cell_if #(
  parameter int unsigned CELL_W = gscw_pkg::CELL_W_DEF
);
  logic                     valid;
  logic                     ready;
  logic signed [CELL_W-1:0] cell_x;
  logic signed [CELL_W-1:0] cell_y;
  logic                     last;
  logic                     truncated;

  modport source (output valid, cell_x, cell_y, last, truncated, input ready);
  modport sink   (input valid, cell_x, cell_y, last, truncated, output ready);
endinterface

`default_nettype wire

// ===== rtl/gscw_seq.sv =====
// Microcode sequencer: step counter, ROM lookup and conditional jumps.
// Depends on gscw_pkg (ROM, control and status types).
`default_nettype none

module gscw_seq (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire gscw_pkg::gscw_stat_t stat_i,
  output gscw_pkg::gscw_ctrl_t     ctrl_o
);
  import gscw_pkg::*;

  gscw_addr_e pc_q, pc_d;
  gscw_ctrl_t cw;
  logic       take;

  assign cw     = gscw_ucode(pc_q);
  assign ctrl_o = cw;

  always_comb begin
    unique case (cw.br)
      BR_ALWAYS:   take = 1'b1;
      BR_ACCEPT:   take = stat_i.accept;
      BR_MUL_DONE: take = stat_i.mul_done;
      BR_WALK_END: take = stat_i.walk_fire & stat_i.walk_last;
      default:     take = 1'b0;
    endcase
    pc_d = take ? cw.target : pc_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= UA_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

`ifndef SYNTHESIS
  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_i.accept |-> pc_q == UA_IDLE)
    else $error("segment word taken outside the idle step");

  a_setup_to_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q == UA_SETUP |=> pc_q == UA_MUL)
    else $error("setup step not followed by multiply loop");

  a_walk_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == UA_WALK && !(stat_i.walk_fire && stat_i.walk_last)) |=> pc_q == UA_WALK)
    else $error("walk left before the final cell");
`endif

endmodule

`default_nettype wire

// ===== rtl/gscw_dp.sv =====
// Datapath of the cell walk: input capture, setup, shift-add products,
// incremental boundary-time compare, cell stepping and output register.
// Depends on gscw_pkg and the channel interfaces in gscw_if.sv.
`default_nettype none

module gscw_dp #(
  parameter int unsigned COORD_INT_BITS = gscw_pkg::COORD_INT_BITS_DEF,
  parameter int unsigned FRAC_BITS      = gscw_pkg::FRAC_BITS_DEF,
  parameter int unsigned MAX_CELLS      = gscw_pkg::MAX_CELLS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire gscw_pkg::gscw_ctrl_t ctrl_i,
  output gscw_pkg::gscw_stat_t      stat_o,
  gscw_seg_if.sink                  seg_i,
  gscw_cell_if.source               cell_o
);
  import gscw_pkg::*;

  localparam int unsigned IN_W   = COORD_INT_BITS + FRAC_BITS + 1;
  localparam int unsigned D_W    = IN_W + 1;
  localparam int unsigned CELL_W = COORD_INT_BITS + 1;
  localparam int unsigned DIST_W = IN_W + 2;
  localparam int unsigned PROD_W = DIST_W + D_W;
  localparam int unsigned MUL_W  = FRAC_BITS + 1;
  localparam int unsigned MCNT_W = $clog2(FRAC_BITS + 2);
  localparam int unsigned STEP_W = $clog2(MAX_CELLS);
  localparam int unsigned LIM_W  = D_W + 1;

  localparam logic [DIST_W-1:0] ONE_DIST  = DIST_W'(1) << FRAC_BITS;
  localparam logic [DIST_W-1:0] FRAC_MASK = ONE_DIST - DIST_W'(1);
  localparam logic [MCNT_W-1:0] MUL_LAST  = MCNT_W'(FRAC_BITS);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(MAX_CELLS - 1);
  localparam logic [LIM_W-1:0]  LIM_PAD   = LIM_W'(4);

  // captured segment
  logic signed [IN_W-1:0] sx_q, sy_q, ex_q, ey_q;
  // walk state
  logic signed [CELL_W-1:0] cur_x_q, cur_y_q;
  logic                     negx_q, negy_q;
  logic [D_W-1:0]           adx_q, ady_q;
  logic [DIST_W-1:0]        nx_q, ny_q;
  logic [MUL_W-1:0]         mx_q, my_q;
  logic [PROD_W-1:0]        tx_q, ty_q;
  logic [MCNT_W-1:0]        mcnt_q;
  logic [STEP_W-1:0]        step_q;
  logic [LIM_W-1:0]         lim_q;
  // output register
  logic                     out_vld_q;
  logic signed [CELL_W-1:0] out_x_q, out_y_q;
  logic                     out_last_q, out_trunc_q;

  // setup terms
  logic signed [D_W-1:0]   dx_c, dy_c;
  logic [D_W-1:0]          adx_c, ady_c;
  logic [DIST_W-1:0]       fx_c, fy_c, nx0_c, ny0_c;
  logic                    posx_c, posy_c;
  logic [LIM_W-1:0]        lim_c;

  // walk terms
  logic nonzero, movex, cross_ok, in_lim, move, at_cap;
  logic w_last, w_trunc, fire, advance, load;

  assign load = ctrl_i.in_ready & seg_i.valid;
  assign seg_i.ready = ctrl_i.in_ready;

  always_comb begin
    dx_c   = $signed({ex_q[IN_W-1], ex_q}) - $signed({sx_q[IN_W-1], sx_q});
    dy_c   = $signed({ey_q[IN_W-1], ey_q}) - $signed({sy_q[IN_W-1], sy_q});
    adx_c  = dx_c[D_W-1] ? D_W'(-dx_c) : D_W'(dx_c);
    ady_c  = dy_c[D_W-1] ? D_W'(-dy_c) : D_W'(dy_c);
    posx_c = !dx_c[D_W-1] && (dx_c != '0);
    posy_c = !dy_c[D_W-1] && (dy_c != '0);
    fx_c   = {{(DIST_W-IN_W){1'b0}}, sx_q} & FRAC_MASK;
    fy_c   = {{(DIST_W-IN_W){1'b0}}, sy_q} & FRAC_MASK;
    // distance to the next boundary in the step direction
    nx0_c  = posx_c ? ONE_DIST - fx_c : fx_c;
    ny0_c  = posy_c ? ONE_DIST - fy_c : fy_c;
    lim_c  = (({1'b0, adx_q} + {1'b0, ady_q}) >> FRAC_BITS) + LIM_PAD;
  end

  always_comb begin
    nonzero  = (adx_q != '0) || (ady_q != '0);
    // x crossing strictly earlier: nx/adx < ny/ady, cross-multiplied
    movex    = (adx_q != '0) && ((ady_q == '0) || (tx_q < ty_q));
    cross_ok = movex ? (nx_q <= DIST_W'(adx_q)) : (ny_q <= DIST_W'(ady_q));
    in_lim   = LIM_W'(step_q) < lim_q;
    move     = nonzero && cross_ok && in_lim;
    at_cap   = step_q == STEP_LAST;
    w_last   = !move || at_cap;
    w_trunc  = move && at_cap;
    fire     = (ctrl_i.op == DP_WALK) && (!out_vld_q || cell_o.ready);
    advance  = fire && !w_last;
  end

  assign stat_o = '{accept:    load,
                    mul_done:  mcnt_q == MUL_LAST,
                    walk_fire: fire,
                    walk_last: w_last};

  always_ff @(posedge clk_i) begin
    if (load) begin
      sx_q <= seg_i.start_x;
      sy_q <= seg_i.start_y;
      ex_q <= seg_i.end_x;
      ey_q <= seg_i.end_y;
    end
    unique case (ctrl_i.op)
      DP_SETUP: begin
        cur_x_q <= CELL_W'(sx_q >>> FRAC_BITS);
        cur_y_q <= CELL_W'(sy_q >>> FRAC_BITS);
        negx_q  <= dx_c[D_W-1];
        negy_q  <= dy_c[D_W-1];
        adx_q   <= adx_c;
        ady_q   <= ady_c;
        nx_q    <= nx0_c;
        ny_q    <= ny0_c;
        mx_q    <= nx0_c[MUL_W-1:0];
        my_q    <= ny0_c[MUL_W-1:0];
        tx_q    <= '0;
        ty_q    <= '0;
        mcnt_q  <= '0;
        step_q  <= '0;
      end
      DP_MUL: begin
        // msb-first shift-add: tx = nx0 * ady, ty = ny0 * adx
        tx_q   <= (tx_q << 1) + (mx_q[MUL_W-1] ? PROD_W'(ady_q) : PROD_W'(0));
        ty_q   <= (ty_q << 1) + (my_q[MUL_W-1] ? PROD_W'(adx_q) : PROD_W'(0));
        mx_q   <= mx_q << 1;
        my_q   <= my_q << 1;
        mcnt_q <= mcnt_q + MCNT_W'(1);
        lim_q  <= lim_c;
      end
      DP_WALK: begin
        if (advance) begin
          step_q <= step_q + STEP_W'(1);
          if (movex) begin
            cur_x_q <= negx_q ? cur_x_q - CELL_W'(1) : cur_x_q + CELL_W'(1);
            nx_q    <= nx_q + ONE_DIST;
            tx_q    <= tx_q + (PROD_W'(ady_q) << FRAC_BITS);
          end else begin
            cur_y_q <= negy_q ? cur_y_q - CELL_W'(1) : cur_y_q + CELL_W'(1);
            ny_q    <= ny_q + ONE_DIST;
            ty_q    <= ty_q + (PROD_W'(adx_q) << FRAC_BITS);
          end
        end
      end
      default: begin
      end
    endcase
    if (fire) begin
      out_x_q     <= cur_x_q;
      out_y_q     <= cur_y_q;
      out_last_q  <= w_last;
      out_trunc_q <= w_trunc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fire) begin
      out_vld_q <= 1'b1;
    end else if (cell_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  assign cell_o.valid     = out_vld_q;
  assign cell_o.cell_x    = out_x_q;
  assign cell_o.cell_y    = out_y_q;
  assign cell_o.last      = out_last_q;
  assign cell_o.truncated = out_trunc_q;

`ifndef SYNTHESIS
  a_trunc_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cell_o.valid && cell_o.truncated) |-> cell_o.last)
    else $error("truncated word that is not the last of its run");

  a_one_axis_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> ((cur_x_q != $past(cur_x_q)) != (cur_y_q != $past(cur_y_q))))
    else $error("walk step did not move exactly one axis");

  a_mul_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.op == DP_SETUP) |=> (mcnt_q == '0 && step_q == '0))
    else $error("setup did not clear the loop counters");
`endif

endmodule

`default_nettype wire

// ===== rtl/grid_segment_cell_walk_unit.sv =====
// Grid segment cell walk: lists every grid cell a fixed-point segment crosses, up to MAX_CELLS.
// After a segment word is taken: one setup step, FRAC_BITS+1 shift-add steps, then the
// first cell word goes into the output register stage.
// Throughput: one cell per cycle after that while cell_o is not stalled; a segment gives
// N cells (at most MAX_CELLS); the next segment can be taken while the final cell still
// waits in the output register.
// Reset: sequencer returns to idle and the output register empties; no clearing pass.
`default_nettype none

module grid_segment_cell_walk_unit #(
  parameter int unsigned COORD_INT_BITS = gscw_pkg::COORD_INT_BITS_DEF,
  parameter int unsigned FRAC_BITS      = gscw_pkg::FRAC_BITS_DEF,
  parameter int unsigned MAX_CELLS      = gscw_pkg::MAX_CELLS_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  gscw_seg_if.sink    seg_i,
  gscw_cell_if.source cell_o
);
  import gscw_pkg::*;

  gscw_ctrl_t ctrl;
  gscw_stat_t stat;

  gscw_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  gscw_dp #(
    .COORD_INT_BITS (COORD_INT_BITS),
    .FRAC_BITS      (FRAC_BITS),
    .MAX_CELLS      (MAX_CELLS)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .stat_o (stat),
    .seg_i  (seg_i),
    .cell_o (cell_o)
  );

endmodule

`default_nettype wire
